/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/set_pkg.sv */
`default_nettype none
package set_pkg;
	localparam int unsigned NumActionsDef = 16;
	localparam int unsigned NumFeaturesDef = 4096;
	localparam int unsigned TraceW = 16;
	localparam int unsigned CountW = 13;
	localparam logic [15:0] TraceOne = 16'd4096;
	localparam logic [15:0] TraceMax = 16'hFFFF;
	localparam logic [12:0] CountMax = 13'h1FFF;
	localparam logic [15:0] DecayRst = 16'd62259;
	localparam logic [15:0] ThreshRst = 16'd41;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [1:0] RegDecay = 2'd0;
	localparam logic [1:0] RegThresh = 2'd1;
	localparam logic [1:0] RegAccum = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DCNT,
		ST_DLIST,
		ST_DTRACE,
		ST_DMUL,
		ST_DWRITE,
		ST_DNEXT,
		ST_UREAD,
		ST_UWAIT,
		ST_UWRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic act_inc;
		logic cnt_load;
		logic list_rd;
		logic trace_rd;
		logic mul;
		logic dec_write;
		logic dec_next;
		logic cnt_store;
		logic upd_rd;
		logic upd_write;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic act_last;
		logic list_done;
		logic out_full;
	} status_t;
endpackage
`default_nettype wire

/* rtl/set_if.sv */
`default_nettype none
interface set_in_if;
	logic valid;
	logic ready;
	logic [3:0] action_index;
	logic [11:0] feature_index;
	logic first_of_step;
	logic last_of_step;
	modport source(output valid, action_index, feature_index, first_of_step, last_of_step,
		input ready);
	modport sink(input valid, action_index, feature_index, first_of_step, last_of_step,
		output ready);
endinterface

interface set_out_if;
	logic valid;
	logic ready;
	logic [15:0] trace_value;
	logic [12:0] active_count;
	logic was_new;
	logic step_done;
	modport source(output valid, trace_value, active_count, was_new, step_done,
		input ready);
	modport sink(input valid, trace_value, active_count, was_new, step_done,
		output ready);
endinterface
`default_nettype wire

/* rtl/set_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"
module set_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_first,
	output logic in_ready,
	input wire set_pkg::status_t sts,
	output set_pkg::cmd_t cmd
);
	set_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= set_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			set_pkg::ST_CLEAR: if (sts.clr_done) state_d = set_pkg::ST_IDLE;
			set_pkg::ST_IDLE: begin
				if (in_valid && !sts.out_full)
					state_d = in_first ? set_pkg::ST_DCNT : set_pkg::ST_UREAD;
			end
			set_pkg::ST_DCNT: state_d = set_pkg::ST_DLIST;
			set_pkg::ST_DLIST: begin
				if (sts.list_done) begin
					state_d = sts.act_last ? set_pkg::ST_UREAD : set_pkg::ST_DCNT;
				end else begin
					state_d = set_pkg::ST_DTRACE;
				end
			end
			set_pkg::ST_DTRACE: state_d = set_pkg::ST_DMUL;
			set_pkg::ST_DMUL: state_d = set_pkg::ST_DWRITE;
			set_pkg::ST_DWRITE: state_d = set_pkg::ST_DNEXT;
			set_pkg::ST_DNEXT: state_d = set_pkg::ST_DLIST;
			set_pkg::ST_UREAD: state_d = set_pkg::ST_UWAIT;
			set_pkg::ST_UWAIT: state_d = set_pkg::ST_UWRITE;
			set_pkg::ST_UWRITE: state_d = set_pkg::ST_OUT;
			set_pkg::ST_OUT: state_d = set_pkg::ST_IDLE;
			default: state_d = set_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			set_pkg::ST_IDLE: begin
				in_ready = !sts.out_full;
				cmd.clr_step = in_valid && !sts.out_full;
			end
			set_pkg::ST_DCNT: cmd.cnt_load = 1'b1;
			set_pkg::ST_DLIST: begin
				cmd.list_rd = !sts.list_done;
				cmd.cnt_store = sts.list_done;
				cmd.act_inc = sts.list_done;
			end
			set_pkg::ST_DTRACE: cmd.trace_rd = 1'b1;
			set_pkg::ST_DMUL: cmd.mul = 1'b1;
			set_pkg::ST_DWRITE: cmd.dec_write = 1'b1;
			set_pkg::ST_DNEXT: cmd.dec_next = 1'b1;
			set_pkg::ST_UREAD: cmd.upd_rd = 1'b1;
			set_pkg::ST_UWRITE: cmd.upd_write = 1'b1;
			set_pkg::ST_OUT: cmd.out_load = 1'b1;
			default: cmd = '0;
		endcase
	end

	`ASSERT_NEXT(a_out_idle, clk, arst_n, state_q == set_pkg::ST_OUT, state_q == set_pkg::ST_IDLE)
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready |-> state_q == set_pkg::ST_IDLE)
	`ASSERT_NEXT(a_write_out, clk, arst_n, state_q == set_pkg::ST_UWRITE,
		state_q == set_pkg::ST_OUT)
endmodule
`default_nettype wire

/* rtl/set_dp.sv */
`default_nettype none
`include "assert_macros.svh"
module set_dp #(
	parameter int unsigned NUM_ACTIONS = set_pkg::NumActionsDef,
	parameter int unsigned NUM_FEATURES = set_pkg::NumFeaturesDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire set_pkg::cmd_t cmd,
	output set_pkg::status_t sts,
	input wire logic cfg_we,
	input wire logic [set_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	input wire logic [3:0] in_action,
	input wire logic [11:0] in_feature,
	input wire logic in_last,
	input wire logic out_ready,
	output logic out_valid,
	output logic [15:0] out_trace,
	output logic [12:0] out_count,
	output logic out_new,
	output logic out_done
);
	localparam int unsigned AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int unsigned FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int unsigned MW = AW + FW;
	localparam int unsigned DEPTH = 1 << MW;
	localparam int unsigned NW = FW + 1;

	// The trace memory is zeroed by a clearing pass after reset. The list memory
	// needs no clearing, since an entry is only read below its action's count.
	logic [15:0] trace_mem [DEPTH];
	logic [FW-1:0] list_mem [DEPTH];
	logic [NW-1:0] cnt_q [NUM_ACTIONS];

	logic [15:0] decay_q, thresh_q;
	logic accum_q;
	logic [MW:0] clr_q;
	logic [AW:0] act_q;
	logic [NW-1:0] n_q, rd_q, kept_q;
	logic [FW-1:0] feat_q;
	logic [15:0] trd_q;
	logic [31:0] prod_q;
	logic [3:0] in_act_q;
	logic [11:0] in_feat_q;
	logic in_last_q, ok_q;
	logic [15:0] trace_rd_q;
	logic [NW-1:0] ucnt_q;
	logic [15:0] new_t_q;
	logic new_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= set_pkg::DecayRst;
			thresh_q <= set_pkg::ThreshRst;
			accum_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				set_pkg::RegDecay: decay_q <= cfg_data;
				set_pkg::RegThresh: thresh_q <= cfg_data;
				set_pkg::RegAccum: accum_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic clr_busy;
	assign clr_busy = !clr_q[MW];
	assign sts.clr_done = clr_q[MW] || (clr_q[MW-1:0] == MW'(DEPTH - 1));

	logic [AW-1:0] act_i;
	assign act_i = act_q[AW-1:0];
	logic [MW-1:0] dbase;
	assign dbase = MW'(act_i) << FW;

	assign sts.act_last = (act_q == (AW+1)'(NUM_ACTIONS - 1));
	assign sts.list_done = (rd_q >= n_q);
	assign sts.out_full = out_valid;

	logic in_ok;
	assign in_ok = (32'(in_action) < NUM_ACTIONS) && (32'(in_feature) < NUM_FEATURES);
	logic [AW-1:0] uact;
	assign uact = AW'(in_act_q);
	logic [FW-1:0] ufeat;
	assign ufeat = FW'(in_feat_q);
	logic [MW-1:0] uaddr;
	assign uaddr = (MW'(uact) << FW) | MW'(ufeat);

	logic [15:0] dec_t;
	assign dec_t = prod_q[31:16];
	logic keep;
	assign keep = (dec_t != 16'd0) && (dec_t >= thresh_q);

	logic [MW-1:0] taddr;
	always_comb begin
		taddr = uaddr;
		if (clr_busy) taddr = clr_q[MW-1:0];
		else if (cmd.trace_rd || cmd.dec_write) taddr = dbase | MW'(feat_q);
	end

	// Trace memory: one port, written by clear, decay and update.
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			trace_mem[taddr] <= '0;
		end else if (cmd.dec_write) begin
			trace_mem[taddr] <= keep ? dec_t : 16'd0;
		end else if (cmd.upd_write && ok_q) begin
			trace_mem[taddr] <= new_t_q;
		end
		trd_q <= trace_mem[taddr];
	end

	// List memory: read during the walk, compacted in place, appended on update.
	logic [MW-1:0] laddr;
	logic lwe;
	logic [FW-1:0] ldata;
	always_comb begin
		lwe = 1'b0;
		ldata = feat_q;
		laddr = dbase | MW'(rd_q[FW-1:0]);
		if (cmd.dec_write) begin
			lwe = keep;
			laddr = dbase | MW'(kept_q[FW-1:0]);
		end else if (cmd.upd_write) begin
			lwe = ok_q && new_q && (ucnt_q < NW'(NUM_FEATURES));
			ldata = ufeat;
			laddr = (MW'(uact) << FW) | MW'(ucnt_q[FW-1:0]);
		end
	end
	always_ff @(posedge clk) begin
		if (lwe) list_mem[laddr] <= ldata;
		if (cmd.list_rd) feat_q <= list_mem[laddr];
	end

	logic [NW-1:0] cnt_rd;
	assign cnt_rd = cnt_q[uact];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < NUM_ACTIONS; i++) cnt_q[i] <= '0;
			act_q <= '0;
		end else begin
			if (clr_busy) clr_q <= clr_q + 1'b1;
			if (cmd.clr_step) act_q <= '0;
			else if (cmd.act_inc) act_q <= act_q + 1'b1;
			if (cmd.cnt_store) cnt_q[act_i] <= kept_q;
			if (cmd.upd_write && ok_q && new_q && (ucnt_q < NW'(NUM_FEATURES)))
				cnt_q[uact] <= ucnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			in_act_q <= in_action;
			in_feat_q <= in_feature;
			in_last_q <= in_last;
			ok_q <= in_ok;
		end
		if (cmd.cnt_load) begin
			n_q <= cnt_q[act_i];
			rd_q <= '0;
			kept_q <= '0;
		end
		if (cmd.mul) prod_q <= 32'(trd_q) * 32'(decay_q);
		if (cmd.dec_next) begin
			rd_q <= rd_q + 1'b1;
			if (keep) kept_q <= kept_q + 1'b1;
		end
		if (cmd.upd_rd) ucnt_q <= cnt_rd;
		trace_rd_q <= trd_q;
		if (cmd.upd_write) begin
			ucnt_q <= (new_q && ucnt_q < NW'(NUM_FEATURES)) ? ucnt_q + 1'b1 : ucnt_q;
		end
	end

	// Compute the new trace combinationally from the registered copy of the read data.
	always_comb begin
		new_q = (trace_rd_q == 16'd0);
		if (accum_q) begin
			new_t_q = (trace_rd_q > set_pkg::TraceMax - set_pkg::TraceOne) ?
				set_pkg::TraceMax : trace_rd_q + set_pkg::TraceOne;
		end else begin
			new_t_q = set_pkg::TraceOne;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_done <= in_last_q;
			if (ok_q) begin
				out_trace <= new_t_q;
				out_new <= new_q;
				out_count <= (ucnt_q > NW'(set_pkg::CountMax)) ? set_pkg::CountMax :
					13'(ucnt_q);
			end else begin
				out_trace <= '0;
				out_new <= 1'b0;
				out_count <= '0;
			end
		end
	end

	`ASSERT_IMPL(a_no_work_clear, clk, arst_n, clr_busy |-> !cmd.upd_write && !cmd.dec_write)
	`ASSERT_IMPL(a_kept_le, clk, arst_n, cmd.cnt_store |-> kept_q <= n_q)
	`ASSERT_NEXT(a_out_set, clk, arst_n, cmd.out_load, out_valid)
endmodule
`default_nettype wire

/* rtl/sparse_eligibility_trace_update.sv */
// Sparse eligibility trace table for one action-value learner.
// Input channel: one word per active feature, with action, feature and step flags.
// Output channel: one word per input word, giving the new trace, the list length
// of that action, whether the entry was newly listed and the step-end flag.
// A word without first_of_step passes through UREAD, UWAIT, UWRITE and OUT before
// its result is registered as valid in the output register.
// A word with first_of_step first walks every listed trace of every action,
// through DCNT and DLIST per action and DLIST, DTRACE, DMUL, DWRITE and DNEXT per
// listed trace, set by the single port of the trace memory and the registered multiply.
// One word is in work at a time; a new word is taken once the output register
// is empty, so a stalled receiver holds the block after one pending result.
// After reset the trace memory is cleared, one entry a cycle, over the table
// padded to powers of two (65536 entries by default); no word is accepted then.
// Configuration writes are taken at any time and should be issued while idle.
`default_nettype none
module sparse_eligibility_trace_update #(
	parameter int unsigned NUM_ACTIONS = set_pkg::NumActionsDef,
	parameter int unsigned NUM_FEATURES = set_pkg::NumFeaturesDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [set_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	set_in_if.sink in_ch,
	set_out_if.source out_ch
);
	set_pkg::cmd_t cmd;
	set_pkg::status_t sts;

	set_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_first(in_ch.first_of_step),
		.in_ready(in_ch.ready), .sts(sts), .cmd(cmd)
	);

	set_dp #(.NUM_ACTIONS(NUM_ACTIONS), .NUM_FEATURES(NUM_FEATURES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_action(in_ch.action_index), .in_feature(in_ch.feature_index),
		.in_last(in_ch.last_of_step), .out_ready(out_ch.ready),
		.out_valid(out_ch.valid), .out_trace(out_ch.trace_value),
		.out_count(out_ch.active_count), .out_new(out_ch.was_new),
		.out_done(out_ch.step_done)
	);
endmodule
`default_nettype wire

/* verif/sparse_eligibility_trace_check.sv */
`default_nettype none
module sparse_eligibility_trace_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [set_pkg::CfgIdxW-1:0] cfg_idx,
	input wire logic [15:0] cfg_data,
	set_in_if in_mon,
	set_out_if out_mon,
	output int unsigned err_count,
	output int unsigned pending,
	output int unsigned words_checked
);
	localparam int unsigned NA = set_pkg::NumActionsDef;
	localparam int unsigned NF = set_pkg::NumFeaturesDef;

	typedef struct packed {
		logic [15:0] trace_value;
		logic [12:0] active_count;
		logic was_new;
		logic step_done;
	} trace_word_t;

	logic [15:0] trace_mem [NA*NF];
	logic [11:0] feat_list [NA*NF];
	logic [12:0] list_len [NA];
	logic [15:0] decay_q;
	logic [15:0] thresh_q;
	logic accum_q;
	trace_word_t expected_words [$];

	// Scale every listed trace by the decay factor and compact each action's list.
	function automatic void decay_lists();
		int unsigned kept;
		int unsigned f;
		logic [31:0] prod;
		for (int a = 0; a < NA; a++) begin
			kept = 0;
			for (int i = 0; i < list_len[a]; i++) begin
				f = feat_list[a*NF + i];
				prod = (32'(trace_mem[a*NF + f]) * 32'(decay_q)) >> 16;
				if (prod == 0 || prod < 32'(thresh_q)) begin
					trace_mem[a*NF + f] = '0;
				end else begin
					trace_mem[a*NF + f] = prod[15:0];
					feat_list[a*NF + kept] = f[11:0];
					kept++;
				end
			end
			list_len[a] = 13'(kept);
		end
	endfunction

	function automatic trace_word_t next_trace(logic [3:0] act, logic [11:0] feat,
			logic first, logic last);
		trace_word_t w;
		int unsigned idx;
		logic [16:0] t;
		if (first)
			decay_lists();
		idx = act*NF + feat;
		t = {1'b0, trace_mem[idx]};
		w.was_new = 1'b0;
		if (t == 0) begin
			if (list_len[act] < NF) begin
				feat_list[act*NF + list_len[act]] = feat;
				list_len[act] = list_len[act] + 1;
			end
			w.was_new = 1'b1;
		end
		if (accum_q) begin
			t = t + 17'(set_pkg::TraceOne);
			if (t > 17'(set_pkg::TraceMax))
				t = 17'(set_pkg::TraceMax);
		end else begin
			t = 17'(set_pkg::TraceOne);
		end
		trace_mem[idx] = t[15:0];
		w.trace_value = t[15:0];
		w.active_count = (list_len[act] > set_pkg::CountMax) ? set_pkg::CountMax :
			list_len[act];
		w.step_done = last;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		trace_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < NA*NF; i++) begin
				trace_mem[i] = '0;
				feat_list[i] = '0;
			end
			for (int a = 0; a < NA; a++)
				list_len[a] = '0;
			decay_q = set_pkg::DecayRst;
			thresh_q = set_pkg::ThreshRst;
			accum_q = 1'b0;
			expected_words.delete();
			err_count = 0;
			words_checked = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_words.size() == 0) begin
					err_count++;
					$display("%0t: result word with nothing expected: trace %0d count %0d",
						$time, out_mon.trace_value, out_mon.active_count);
				end else begin
					e = expected_words.pop_front();
					words_checked++;
					if (out_mon.trace_value !== e.trace_value) begin
						err_count++;
						$display("%0t: trace_value expected %0d actual %0d",
							$time, e.trace_value, out_mon.trace_value);
					end
					if (out_mon.active_count !== e.active_count) begin
						err_count++;
						$display("%0t: active_count expected %0d actual %0d",
							$time, e.active_count, out_mon.active_count);
					end
					if (out_mon.was_new !== e.was_new) begin
						err_count++;
						$display("%0t: was_new expected %0b actual %0b",
							$time, e.was_new, out_mon.was_new);
					end
					if (out_mon.step_done !== e.step_done) begin
						err_count++;
						$display("%0t: step_done expected %0b actual %0b",
							$time, e.step_done, out_mon.step_done);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_words = {expected_words, next_trace(in_mon.action_index,
					in_mon.feature_index, in_mon.first_of_step, in_mon.last_of_step)};
			if (cfg_we) begin
				case (cfg_idx)
					set_pkg::RegDecay: decay_q = cfg_data;
					set_pkg::RegThresh: thresh_q = cfg_data;
					set_pkg::RegAccum: accum_q = cfg_data[0];
					default: ;
				endcase
			end
		end
		pending = expected_words.size();
	end
endmodule
`default_nettype wire

/* verif/sparse_eligibility_trace_update_tb.sv */
`default_nettype none
module sparse_eligibility_trace_update_tb;
	localparam logic [1:0] RegUnused = 2'd3;
	localparam int unsigned CycleLimit = 10000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [set_pkg::CfgIdxW-1:0] cfg_idx = set_pkg::RegDecay;
	logic [15:0] cfg_data = '0;
	int unsigned err_count;
	int unsigned pending;
	int unsigned words_checked;
	int unsigned words_sent = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;
	bit long_hold = 1'b0;

	set_in_if in_ch();
	set_out_if out_ch();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action_index = '0;
		in_ch.feature_index = '0;
		in_ch.first_of_step = 1'b0;
		in_ch.last_of_step = 1'b0;
		out_ch.ready = 1'b0;
	end

	always #5 clk = ~clk;

	sparse_eligibility_trace_update u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	sparse_eligibility_trace_check u_check (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
		.err_count(err_count), .pending(pending), .words_checked(words_checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: when rx_stalls is set, stalls a random number of cycles before taking each word.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = rx_stalls ? $urandom_range(0, 18) : 0;
			if (long_hold) begin
				stall = 400;
				long_hold = 1'b0;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	task automatic send_word(logic [3:0] act, logic [11:0] feat, logic first, logic last);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.action_index <= act;
		in_ch.feature_index <= feat;
		in_ch.first_of_step <= first;
		in_ch.last_of_step <= last;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		words_sent++;
	endtask

	// Drains the block, then writes all registers plus an unused index.
	task automatic program_regs(logic [15:0] decay, logic [15:0] thresh, logic accum);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= set_pkg::RegDecay;
		cfg_data <= decay;
		@(posedge clk);
		cfg_idx <= set_pkg::RegThresh;
		cfg_data <= thresh;
		@(posedge clk);
		cfg_idx <= set_pkg::RegAccum;
		cfg_data <= {15'($urandom), accum};
		@(posedge clk);
		cfg_idx <= RegUnused;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Features mostly come from a small pool so the lists stay short.
	function automatic logic [11:0] pick_feature();
		if ($urandom_range(0, 9) == 0)
			return 12'($urandom);
		return 12'($urandom_range(0, 15));
	endfunction

	task automatic random_phase(int unsigned count);
		int unsigned len;
		int unsigned n;
		n = 0;
		tx_gaps = $urandom_range(0, 3) != 0;
		rx_stalls = $urandom_range(0, 3) != 0;
		while (n < count) begin
			if ($urandom_range(0, 7) == 0) begin
				send_word(4'($urandom), pick_feature(), 1'($urandom), 1'($urandom));
				n++;
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_word(4'($urandom), pick_feature(), i == 0, i == len - 1);
				n += len;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, corner indexes, repeated entry.
		send_word(4'd0, 12'd0, 1'b1, 1'b1);
		send_word(4'd15, 12'd4095, 1'b0, 1'b0);
		send_word(4'd15, 12'd4095, 1'b0, 1'b1);
		send_word(4'd7, 12'd2730, 1'b1, 1'b0);
		send_word(4'd8, 12'd1365, 1'b0, 1'b1);
		// Accumulating with no decay until the trace saturates.
		program_regs(16'hFFFF, 16'd0, 1'b1);
		for (int i = 0; i < 17; i++)
			send_word(4'd3, 12'd5, i == 0, i == 16);
		// Zero decay must empty every list even with a zero threshold.
		program_regs(16'd0, 16'd0, 1'b0);
		send_word(4'd0, 12'd1, 1'b1, 1'b1);
		// Maximum threshold prunes everything that survives the decay.
		program_regs(16'hFFFF, 16'hFFFF, 1'b1);
		send_word(4'd1, 12'd2, 1'b0, 1'b0);
		send_word(4'd1, 12'd2, 1'b1, 1'b1);

		program_regs(set_pkg::DecayRst, set_pkg::ThreshRst, 1'b0);
		random_phase(320);
		program_regs(16'hFFFF, 16'd0, 1'b1);
		long_hold = 1'b1;
		random_phase(320);
		program_regs(16'($urandom_range(40000, 65535)), 16'($urandom_range(0, 4000)), 1'b0);
		random_phase(320);
		program_regs(16'($urandom), 16'($urandom), 1'b1);
		random_phase(320);
		program_regs(16'd0, 16'hFFFF, 1'b0);
		random_phase(60);
		program_regs(set_pkg::DecayRst, set_pkg::ThreshRst, 1'b1);
		random_phase(300);
		program_regs(16'($urandom_range(50000, 65535)), 16'($urandom_range(0, 2000)),
			1'($urandom));
		random_phase(300);

		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		$display("Sent %0d words and checked %0d results over %0d register settings,",
			words_sent, words_checked, settings_used);
		$display("with decay and threshold extremes, saturation and receiver back-pressure.");
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
